// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stable priority queue.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stable priority queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stable priority queue: next-cycle check failed");

`endif

// ===== hdl/spq_pkg.sv =====
// Package for the stable priority queue: widths, status and kind codes,
// and the command struct that the top level sends to every cell. No dependencies.
package spq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int TAG_W     = 16;
    localparam int CLASS_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_LAST = 2'd2;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [CLASS_W-1:0] cls;
    } t_cell_cmd;

endpackage

// ===== hdl/spq_if.sv =====
// Valid/ready channel interfaces of the stable priority queue.
// Depends on spq_pkg for the payload widths.
interface spq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [spq_pkg::TAG_W-1:0]   tag;
    logic [spq_pkg::CLASS_W-1:0] priority_class;

    modport source(output valid, kind, tag, priority_class, input ready);
    modport sink(input valid, kind, tag, priority_class, output ready);
endinterface

interface spq_out_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::TAG_W-1:0]    removed_tag;
    logic [spq_pkg::CLASS_W-1:0]  removed_class;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source(output valid, status, removed_tag, removed_class, occupancy, input ready);
    modport sink(input valid, status, removed_tag, removed_class, occupancy, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue: holds a tag and a class, and on each command
// keeps its entry, takes the new entry, or takes a neighbor's. Depends on spq_pkg.
module spq_cell (
    input  logic                        i_clk,
    input  spq_pkg::t_cell_cmd          i_cmd,
    input  logic                        i_used,
    input  logic                        i_gt_left,
    input  logic [spq_pkg::TAG_W-1:0]   i_new_tag,
    input  logic [spq_pkg::TAG_W-1:0]   i_left_tag,
    input  logic [spq_pkg::CLASS_W-1:0] i_left_class,
    input  logic [spq_pkg::TAG_W-1:0]   i_right_tag,
    input  logic [spq_pkg::CLASS_W-1:0] i_right_class,
    output logic                        o_gt,
    output logic [spq_pkg::TAG_W-1:0]   o_tag,
    output logic [spq_pkg::CLASS_W-1:0] o_class
);

    logic [spq_pkg::TAG_W-1:0]   r_tag;
    logic [spq_pkg::CLASS_W-1:0] r_class;
    logic [spq_pkg::TAG_W-1:0]   n_tag;
    logic [spq_pkg::CLASS_W-1:0] n_class;

    // A free slot or a strictly later class sits behind the insertion point.
    assign o_gt = !i_used || (r_class > i_cmd.cls);

    always_comb begin
        n_tag   = r_tag;
        n_class = r_class;
        if (i_cmd.ins) begin
            if (i_gt_left) begin
                n_tag   = i_left_tag;
                n_class = i_left_class;
            end else if (o_gt) begin
                n_tag   = i_new_tag;
                n_class = i_cmd.cls;
            end
        end else if (i_cmd.rem) begin
            n_tag   = i_right_tag;
            n_class = i_right_class;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_class <= n_class;
    end

    assign o_tag   = r_tag;
    assign o_class = r_class;

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Stable priority queue built from a row of spq_cell slots kept in service order.
// Depends on spq_pkg, spq_if, spq_cell and assert_macros.svh.
//
// Usage:
// The input channel i_in carries one request per transaction: kind selects an
// insert of tag with priority_class (class 3 is treated as class 2) or a removal
// of the head entry. Lower classes are served first; equal classes leave in
// arrival order.
// The output channel o_out returns exactly one result per request: status,
// the removed tag and class (zero unless an entry was removed), and the
// occupancy after the request.
// A result is valid in the cycle after its request is accepted. The block takes
// one request per cycle unless stalled; every cell compares against the request
// in parallel and shifts by at most one slot, so the result register is the only
// stage. A result waits in the output register while the receiver stalls; a new
// request is taken in the same cycle that the pending result is taken.
// Reset empties the queue and drops any pending result; no clearing pass follows.
// An insert into a full queue and a removal from an empty one leave it unchanged.
module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_out_valid;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [spq_pkg::STATUS_W-1:0] n_status;
    logic [spq_pkg::TAG_W-1:0]    r_rm_tag;
    logic [spq_pkg::CLASS_W-1:0]  r_rm_class;
    logic [spq_pkg::OCC_W-1:0]    r_occ;

    logic                         in_fire;
    logic                         is_ins;
    logic                         full;
    logic                         empty;
    spq_pkg::t_cell_cmd           cmd;

    logic [DEPTH-1:0]             w_used;
    logic [DEPTH-1:0]             w_gt;
    logic [spq_pkg::TAG_W-1:0]    w_tag [DEPTH];
    logic [spq_pkg::CLASS_W-1:0]  w_class [DEPTH];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign is_ins     = (i_in.kind == spq_pkg::KIND_INSERT);
    assign full       = (r_count == COUNT_FULL);
    assign empty      = (r_count == '0);

    always_comb begin
        cmd.ins = in_fire && is_ins && !full;
        cmd.rem = in_fire && !is_ins && !empty;
        cmd.cls = (i_in.priority_class > spq_pkg::CLASS_LAST) ? spq_pkg::CLASS_LAST
                                                              : i_in.priority_class;
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (cmd.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        if (is_ins) begin
            n_status = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        end else begin
            n_status = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_REMOVED;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                        gt_left;
            logic [spq_pkg::TAG_W-1:0]   left_tag;
            logic [spq_pkg::CLASS_W-1:0] left_class;
            logic [spq_pkg::TAG_W-1:0]   right_tag;
            logic [spq_pkg::CLASS_W-1:0] right_class;

            assign w_used[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign gt_left    = 1'b0;
                assign left_tag   = '0;
                assign left_class = '0;
            end else begin : g_mid
                assign gt_left    = w_gt[gi-1];
                assign left_tag   = w_tag[gi-1];
                assign left_class = w_class[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_tag   = '0;
                assign right_class = '0;
            end else begin : g_inner
                assign right_tag   = w_tag[gi+1];
                assign right_class = w_class[gi+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (cmd),
                .i_used        (w_used[gi]),
                .i_gt_left     (gt_left),
                .i_new_tag     (i_in.tag),
                .i_left_tag    (left_tag),
                .i_left_class  (left_class),
                .i_right_tag   (right_tag),
                .i_right_class (right_class),
                .o_gt          (w_gt[gi]),
                .o_tag         (w_tag[gi]),
                .o_class       (w_class[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status   <= n_status;
            r_rm_tag   <= cmd.rem ? w_tag[0] : '0;
            r_rm_class <= cmd.rem ? w_class[0] : '0;
            r_occ      <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_tag   = r_rm_tag;
    assign o_out.removed_class = r_rm_class;
    assign o_out.occupancy     = r_occ;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_FULL)
    `SPQ_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, !r_out_valid, i_in.ready)
    `SPQ_ASSERT_NEXT(a_insert_counts, i_clk, i_rst_n, cmd.ins, r_count == $past(r_count) + 1'b1)
    `SPQ_ASSERT_NEXT(a_empty_status, i_clk, i_rst_n, in_fire && !is_ins && empty,
        r_status == spq_pkg::ST_EMPTY && r_count == '0)

endmodule
